### rtl/core/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared constants, codes and types for the hop distance engine.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int MAX_NODES_DEF   = 1024;
  localparam int MAX_RECORDS_DEF = 8192;

  localparam int FIELD_W = 10;
  localparam int DIST_W  = 10;
  localparam int STAT_W  = 2;
  localparam int STAMP_W = 16;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNREACH = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

### rtl/core/bfs_chan_if.sv
// ----------------------------------------------------------------------------
// bfs_chan_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface bfs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [bfs_pkg::FIELD_W-1:0] node_a;
  logic [bfs_pkg::FIELD_W-1:0] node_b;

  modport source (output valid, cmd, node_a, node_b, input ready);
  modport sink   (input valid, cmd, node_a, node_b, output ready);
endinterface

interface bfs_out_if;
  logic                       valid;
  logic                       ready;
  logic [bfs_pkg::DIST_W-1:0] distance;
  logic [bfs_pkg::STAT_W-1:0] status;

  modport source (output valid, distance, status, input ready);
  modport sink   (input valid, distance, status, output ready);
endinterface

### rtl/core/bfs_ram.sv
// ----------------------------------------------------------------------------
// bfs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/bfs_mod.sv
// ----------------------------------------------------------------------------
// bfs_mod
// Reduces a node field modulo the node count: a reciprocal
// multiply estimates the quotient, one compare and subtract fixes the rest.
// ----------------------------------------------------------------------------
module bfs_mod #(
  parameter int MAX_NODES = bfs_pkg::MAX_NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bfs_pkg::FIELD_W-1:0]  value,
  output logic [$clog2(MAX_NODES)-1:0] result,
  output bfs_pkg::mod_stat_t           stat
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int FW = bfs_pkg::FIELD_W;
  localparam int MW = $clog2(MAX_NODES + 1);
  localparam int RS = 20;
  localparam int PW = FW + RS;
  localparam int EW = FW + MW;
  localparam logic [RS-1:0] RECIP = RS'((64'd1 << RS) / MAX_NODES);

  logic [FW-1:0] val_r;
  logic [FW-1:0] quo_r;
  logic [PW-1:0] prod;
  logic [EW-1:0] back;
  logic [EW-1:0] rem0;
  logic [EW-1:0] rem;

  // quotient estimate is exact or one short, so rem0 stays below twice the node count
  assign prod   = PW'(value) * PW'(RECIP);
  assign back   = EW'(quo_r) * EW'(MAX_NODES);
  assign rem0   = EW'(val_r) - back;
  assign result = rem[NW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= stat.busy && !start;
      if (start) begin
        val_r     <= value;
        quo_r     <= FW'(prod >> RS);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem       <= (rem0 >= EW'(MAX_NODES)) ? rem0 - EW'(MAX_NODES) : rem0;
        stat.busy <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/bfs_hop_distance_engine_top.sv
// ----------------------------------------------------------------------------
// bfs_hop_distance_engine_top
// Undirected graph store with breadth-first hop distance queries.
// ----------------------------------------------------------------------------
// One item at a time. Both node fields first pass a modulo unit. An add
// then does two list head read-modify-writes and gives the result; a
// query to itself or an add to a full store goes straight to the result.
// A query walks the adjacency records of each dequeued node in turn, and
// its walk loop waits on the registered reads of the head, record and
// node memories. After reset, list heads and visit stamps are cleared at
// one entry a cycle, and no item is taken during this sweep; the same
// sweep of the stamps runs once every 65535 queries.
// One result item is produced per input item.
module bfs_hop_distance_engine_top #(
  parameter int MAX_NODES   = bfs_pkg::MAX_NODES_DEF,
  parameter int MAX_RECORDS = bfs_pkg::MAX_RECORDS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bfs_in_if.sink    in_ch,
  bfs_out_if.source out_ch
);

  localparam int NW     = $clog2(MAX_NODES);
  localparam int RW     = $clog2(MAX_RECORDS);
  localparam int QW     = $clog2(MAX_NODES + 1);
  localparam int DW     = bfs_pkg::DIST_W;
  localparam int SW     = bfs_pkg::STAMP_W;
  localparam int NODE_W = DW + SW;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_MOD     = 4'd2;
  localparam logic [3:0] S_ADD_A   = 4'd3;
  localparam logic [3:0] S_ADD_AW  = 4'd4;
  localparam logic [3:0] S_ADD_B   = 4'd5;
  localparam logic [3:0] S_ADD_BW  = 4'd6;
  localparam logic [3:0] S_Q_INIT  = 4'd7;
  localparam logic [3:0] S_Q_POP   = 4'd8;
  localparam logic [3:0] S_Q_HEAD  = 4'd9;
  localparam logic [3:0] S_Q_HEADW = 4'd10;
  localparam logic [3:0] S_Q_REC   = 4'd11;
  localparam logic [3:0] S_Q_TGT   = 4'd12;
  localparam logic [3:0] S_Q_VIS   = 4'd13;
  localparam logic [3:0] S_RES     = 4'd14;

  logic [3:0]    state;
  logic [NW-1:0] clr_cnt;
  logic          clr_heads;
  logic          cmd_r;
  logic [RW-1:0] count;
  logic [SW-1:0] qnum;
  logic [SW-1:0] qnum_next;
  logic [QW-1:0] rd;
  logic [QW-1:0] wr;
  logic [DW-1:0] hop_u;
  logic [RW-1:0] rec_ptr;
  logic [NW-1:0] v;
  logic [DW-1:0] res_dist;
  logic [bfs_pkg::STAT_W-1:0] res_status;
  logic          ovalid;
  logic [DW-1:0] odist;
  logic [bfs_pkg::STAT_W-1:0] ostatus;

  logic          mod_start;
  logic [NW-1:0] src;
  logic [NW-1:0] dst;
  bfs_pkg::mod_stat_t stat_a;
  bfs_pkg::mod_stat_t stat_b;

  logic [RW-1:0] slot;
  logic [NW-1:0] tgt;
  logic [RW-1:0] nxt;
  logic          fresh;

  logic              h_we;
  logic [NW-1:0]     h_waddr, h_raddr;
  logic [RW-1:0]     h_wdata, h_rdata;
  logic              r_we;
  logic [RW-1:0]     r_waddr, r_raddr;
  logic [NW+RW-1:0]  r_wdata, r_rdata;
  logic              n_we;
  logic [NW-1:0]     n_waddr, n_raddr;
  logic [NODE_W-1:0] n_wdata, n_rdata;
  logic              q_we;
  logic [NW-1:0]     q_waddr, q_raddr;
  logic [NW-1:0]     q_wdata, q_rdata;

  assign in_ch.ready     = (state == S_IDLE);
  assign mod_start       = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = ovalid;
  assign out_ch.distance = odist;
  assign out_ch.status   = ostatus;

  assign slot      = count + 1'b1;
  assign tgt       = r_rdata[NW+RW-1:RW];
  assign nxt       = r_rdata[RW-1:0];
  assign fresh     = (n_rdata[SW-1:0] != qnum);
  assign qnum_next = qnum + 1'b1;

  bfs_mod #(.MAX_NODES(MAX_NODES)) u_mod_a (
    .clk(clk), .rst(rst), .start(mod_start), .value(in_ch.node_a),
    .result(src), .stat(stat_a)
  );

  bfs_mod #(.MAX_NODES(MAX_NODES)) u_mod_b (
    .clk(clk), .rst(rst), .start(mod_start), .value(in_ch.node_b),
    .result(dst), .stat(stat_b)
  );

  bfs_ram #(.W(RW), .D(MAX_NODES)) u_head_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  bfs_ram #(.W(NW + RW), .D(MAX_RECORDS)) u_rec_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  bfs_ram #(.W(NODE_W), .D(MAX_NODES)) u_node_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  bfs_ram #(.W(NW), .D(MAX_NODES)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // memory port steering
  always_comb begin
    h_we    = 1'b0;
    h_waddr = src;
    h_wdata = slot;
    h_raddr = src;
    r_we    = 1'b0;
    r_waddr = slot;
    r_wdata = {dst, h_rdata};
    r_raddr = rec_ptr;
    n_we    = 1'b0;
    n_waddr = v;
    n_wdata = {DW'(hop_u + 1'b1), qnum};
    n_raddr = tgt;
    q_we    = 1'b0;
    q_waddr = wr[NW-1:0];
    q_wdata = v;
    q_raddr = rd[NW-1:0];
    case (state)
      S_CLEAR: begin
        h_we    = clr_heads;
        h_waddr = clr_cnt;
        h_wdata = '0;
        n_we    = 1'b1;
        n_waddr = clr_cnt;
        n_wdata = '0;
      end
      S_ADD_AW: begin
        h_we = 1'b1;
        r_we = 1'b1;
      end
      S_ADD_B: begin
        h_raddr = dst;
      end
      S_ADD_BW: begin
        h_we    = 1'b1;
        h_waddr = dst;
        r_we    = 1'b1;
        r_wdata = {src, h_rdata};
      end
      S_Q_INIT: begin
        n_we    = 1'b1;
        n_waddr = src;
        n_wdata = {{DW{1'b0}}, qnum};
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = src;
      end
      S_Q_HEAD: begin
        h_raddr = q_rdata;
        n_raddr = q_rdata;
      end
      S_Q_VIS: begin
        n_we = fresh;
        q_we = fresh;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      clr_heads <= 1'b1;
      count     <= '0;
      qnum      <= '0;
      rd        <= '0;
      wr        <= '0;
      ovalid    <= 1'b0;
    end else begin
      if (ovalid && out_ch.ready && state != S_RES) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_cnt == NW'(MAX_NODES - 1)) begin
            clr_cnt   <= '0;
            clr_heads <= 1'b0;
            state     <= clr_heads ? S_IDLE : S_Q_INIT;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r <= in_ch.cmd;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (stat_a.done && stat_b.done) begin
            res_dist   <= '0;
            res_status <= bfs_pkg::ST_OK;
            if (cmd_r == bfs_pkg::CMD_ADD) begin
              if (count >= RW'(MAX_RECORDS - 2)) begin
                res_status <= bfs_pkg::ST_FULL;
                state      <= S_RES;
              end else begin
                state <= S_ADD_A;
              end
            end else if (src == dst) begin
              state <= S_RES;
            end else if (qnum_next == '0) begin
              // stamp wrap: sweep old marks before this query
              qnum  <= SW'(1);
              state <= S_CLEAR;
            end else begin
              qnum  <= qnum_next;
              state <= S_Q_INIT;
            end
          end
        end
        S_ADD_A: state <= S_ADD_AW;
        S_ADD_AW: begin
          count <= slot;
          state <= S_ADD_B;
        end
        S_ADD_B: state <= S_ADD_BW;
        S_ADD_BW: begin
          count <= slot;
          state <= S_RES;
        end
        S_Q_INIT: begin
          rd    <= '0;
          wr    <= QW'(1);
          state <= S_Q_POP;
        end
        S_Q_POP: begin
          if (rd == wr) begin
            res_status <= bfs_pkg::ST_UNREACH;
            state      <= S_RES;
          end else begin
            rd    <= rd + 1'b1;
            state <= S_Q_HEAD;
          end
        end
        S_Q_HEAD: state <= S_Q_HEADW;
        S_Q_HEADW: begin
          hop_u   <= n_rdata[NODE_W-1:SW];
          rec_ptr <= h_rdata;
          state   <= S_Q_REC;
        end
        S_Q_REC: begin
          state <= (rec_ptr == '0) ? S_Q_POP : S_Q_TGT;
        end
        S_Q_TGT: begin
          if (tgt == dst) begin
            res_dist <= DW'(hop_u + 1'b1);
            state    <= S_RES;
          end else begin
            v       <= tgt;
            rec_ptr <= nxt;
            state   <= S_Q_VIS;
          end
        end
        S_Q_VIS: begin
          if (fresh) begin
            wr <= wr + 1'b1;
          end
          state <= S_Q_REC;
        end
        S_RES: begin
          if (!ovalid || out_ch.ready) begin
            odist   <= res_dist;
            ostatus <= res_status;
            ovalid  <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // queue never holds more entries than there are nodes
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (wr <= QW'(MAX_NODES)) && (rd <= wr))
    else $error("frontier queue pointers out of range");

  a_stamp_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_Q_POP) |-> (qnum != '0))
    else $error("search running with a zero stamp");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= RW'(MAX_RECORDS - 1))
    else $error("record count past store size");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(ovalid) |-> $past(state == S_RES))
    else $error("result transfer raised outside result state");

endmodule
